>>> rtl/p1305_pkg.sv
// ----------------------------------------------------------------------------
// Poly1305 MAC package
// Shared widths, clamp masks, register indexes, state codes and the types
// that pass between the front end, the queue and the arithmetic core.
// ----------------------------------------------------------------------------
package p1305_pkg;

  localparam int unsigned NumLimbs = 5;
  localparam int unsigned LimbW    = 26;
  localparam int unsigned AccW     = 27;
  localparam int unsigned SumW     = 28;
  localparam int unsigned CoefW    = 29;
  localparam int unsigned ProdW    = 57;
  localparam int unsigned DigW     = 62;
  localparam int unsigned CarryW   = 36;
  localparam int unsigned BlkW     = 129;

  localparam logic [63:0] ClampLow  = 64'h0fff_fffc_0fff_ffff;
  localparam logic [63:0] ClampHigh = 64'h0fff_fffc_0fff_fffc;
  localparam logic [4:0]  FullBlockBytes = 5'd16;

  typedef enum logic [1:0] {
    REG_KEY_R_LOW  = 2'd0,
    REG_KEY_R_HIGH = 2'd1,
    REG_KEY_S_LOW  = 2'd2,
    REG_KEY_S_HIGH = 2'd3
  } p1305_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_WRAP = 6'b001000,
    ST_FIN1 = 6'b010000,
    ST_FIN2 = 6'b100000
  } p1305_state_e;

  typedef struct packed {
    logic [BlkW-1:0] blk;
    logic            absorb;
    logic            last;
  } p1305_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } p1305_fifo_st_t;

  typedef struct packed {
    logic idle;
    logic fin;
  } p1305_core_st_t;

endpackage

>>> rtl/p1305_front.sv
// ----------------------------------------------------------------------------
// Poly1305 front end
// Accepts message blocks, masks unused bytes, appends the pad bit and drops
// items that neither absorb data nor finish a message.
// ----------------------------------------------------------------------------
module p1305_front (
  input  logic [63:0]                block_low_i,
  input  logic [63:0]                block_high_i,
  input  logic [4:0]                 block_bytes_i,
  input  logic                       last_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  p1305_pkg::p1305_fifo_st_t  fifo_st_i,
  output logic                       push_o,
  output p1305_pkg::p1305_item_t     item_o
);
  import p1305_pkg::*;

  logic [4:0]      nbytes;
  logic [127:0]    data;
  logic [BlkW-1:0] blk;

  always_comb begin
    nbytes = (block_bytes_i > FullBlockBytes) ? FullBlockBytes : block_bytes_i;
    data   = {block_high_i, block_low_i};
    blk    = '0;
    for (int b = 0; b < 16; b++) begin
      if (5'(b) < nbytes) begin
        blk[8*b +: 8] = data[8*b +: 8];
      end
    end
    for (int b = 0; b <= 16; b++) begin
      if (5'(b) == nbytes) begin
        blk[8*b] = 1'b1;
      end
    end
  end

  assign in_ready_o    = !fifo_st_i.full;
  assign push_o        = in_valid_i && in_ready_o && ((nbytes != 5'd0) || last_i);
  assign item_o.blk    = blk;
  assign item_o.absorb = (nbytes != 5'd0);
  assign item_o.last   = last_i;

endmodule

>>> rtl/p1305_fifo.sv
// ----------------------------------------------------------------------------
// Poly1305 item queue
// Short first-in first-out queue between the front end and the core.
// ----------------------------------------------------------------------------
module p1305_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  p1305_pkg::p1305_item_t     item_i,
  input  logic                       pop_i,
  output p1305_pkg::p1305_item_t     item_o,
  output p1305_pkg::p1305_fifo_st_t  st_o
);
  import p1305_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  p1305_item_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o   = mem_q[rd_ptr_q];
  assign st_o.full  = (cnt_q == CntW'(Depth));
  assign st_o.empty = (cnt_q == '0);

endmodule

>>> rtl/p1305_core.sv
// ----------------------------------------------------------------------------
// Poly1305 arithmetic core
// Adds each block to the accumulator and multiplies by r modulo 2^130-5, one
// limb row per cycle with a running carry, then reduces and adds s on the
// final item of a message.
// ----------------------------------------------------------------------------
module p1305_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  p1305_pkg::p1305_fifo_st_t  fifo_st_i,
  input  p1305_pkg::p1305_item_t     item_i,
  output logic                       pop_o,
  input  logic [127:0]               key_r_i,
  input  logic [127:0]               key_s_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [127:0]               tag_o,
  output p1305_pkg::p1305_core_st_t  st_o
);
  import p1305_pkg::*;

  localparam logic [2:0] LastRow = 3'(NumLimbs - 1);

  p1305_state_e     state_q, state_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             last_q;
  logic             prod_v_q;
  logic [2:0]       prod_k_q;
  logic             out_valid_q;
  logic [127:0]     tag_q;

  logic [SumW-1:0]   hs_q   [NumLimbs];
  logic [CoefW-1:0]  coef_q [NumLimbs];
  logic [LimbW-1:0]  rsh_q  [NumLimbs-1];
  logic [ProdW-1:0]  prod_q [NumLimbs];
  logic [CarryW-1:0] carry_q;
  logic [AccW-1:0]   acc_q  [NumLimbs];
  logic [AccW-1:0]   fin_q  [NumLimbs];

  logic pop, load, mul, wrap, fin1, fin2;

  logic [127:0]      rc;
  logic [LimbW-1:0]  rl [NumLimbs];
  logic [LimbW-1:0]  tl [NumLimbs];
  logic [DigW-1:0]   full;
  logic [38:0]       h0w;
  logic [SumW-1:0]   x  [NumLimbs];
  logic [SumW-1:0]   g  [NumLimbs];
  logic [SumW-1:0]   hf [NumLimbs];
  logic [SumW-1:0]   c_red;
  logic [SumW-1:0]   c_g;
  logic              sel;
  logic [63:0]       lo, hi;
  logic [127:0]      tag_d;

  function automatic logic [CoefW-1:0] times5(input logic [LimbW-1:0] v);
    times5 = CoefW'(v) + (CoefW'(v) << 2);
  endfunction

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pop     = 1'b0;
    load    = 1'b0;
    mul     = 1'b0;
    wrap    = 1'b0;
    fin1    = 1'b0;
    fin2    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!fifo_st_i.empty) begin
          pop = 1'b1;
          if (item_i.absorb) begin
            load    = 1'b1;
            cnt_d   = '0;
            state_d = ST_MUL;
          end else begin
            state_d = ST_FIN1;
          end
        end
      end
      ST_MUL: begin
        mul = 1'b1;
        if (cnt_q == LastRow) begin
          state_d = ST_SUM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SUM: begin
        state_d = ST_WRAP;
      end
      ST_WRAP: begin
        wrap    = 1'b1;
        state_d = last_q ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1: begin
        fin1    = 1'b1;
        state_d = ST_FIN2;
      end
      ST_FIN2: begin
        if (!out_valid_q || out_ready_i) begin
          fin2    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rc = {key_r_i[127:64] & ClampHigh, key_r_i[63:0] & ClampLow};
    for (int i = 0; i < NumLimbs - 1; i++) begin
      rl[i] = rc[LimbW*i +: LimbW];
      tl[i] = item_i.blk[LimbW*i +: LimbW];
    end
    rl[NumLimbs-1] = {2'b00, rc[127:104]};
    tl[NumLimbs-1] = {1'b0, item_i.blk[BlkW-1:104]};
  end

  always_comb begin
    full = DigW'(carry_q);
    for (int i = 0; i < NumLimbs; i++) begin
      full = full + DigW'(prod_q[i]);
    end
    h0w = 39'(acc_q[0][LimbW-1:0]) + 39'(carry_q) + (39'(carry_q) << 2);
  end

  always_comb begin
    for (int i = 0; i < NumLimbs; i++) begin
      x[i] = SumW'(acc_q[i]);
    end
    for (int i = 1; i < NumLimbs - 1; i++) begin
      c_red    = x[i] >> LimbW;
      x[i]     = x[i] & SumW'({LimbW{1'b1}});
      x[i+1]   = x[i+1] + c_red;
    end
    c_red = x[NumLimbs-1] >> LimbW;
    x[NumLimbs-1] = x[NumLimbs-1] & SumW'({LimbW{1'b1}});
    x[0]  = x[0] + c_red + (c_red << 2);
    c_red = x[0] >> LimbW;
    x[0]  = x[0] & SumW'({LimbW{1'b1}});
    x[1]  = x[1] + c_red;
  end

  always_comb begin
    g[0] = SumW'(fin_q[0]) + SumW'(5);
    c_g  = g[0] >> LimbW;
    g[0] = g[0] & SumW'({LimbW{1'b1}});
    for (int i = 1; i < NumLimbs - 1; i++) begin
      g[i] = SumW'(fin_q[i]) + c_g;
      c_g  = g[i] >> LimbW;
      g[i] = g[i] & SumW'({LimbW{1'b1}});
    end
    g[NumLimbs-1] = SumW'(fin_q[NumLimbs-1]) + c_g;
    sel = |g[NumLimbs-1][SumW-1:LimbW];
    g[NumLimbs-1] = g[NumLimbs-1] & SumW'({LimbW{1'b1}});
    for (int i = 0; i < NumLimbs; i++) begin
      hf[i] = sel ? g[i] : SumW'(fin_q[i]);
    end
    lo = 64'(hf[0]) | (64'(hf[1]) << 26) | (64'(hf[2]) << 52);
    hi = 64'(hf[2] >> 12) | (64'(hf[3]) << 14) | (64'(hf[4]) << 40);
    tag_d = {hi, lo} + key_s_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      prod_k_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      prod_v_q <= mul;
      prod_k_q <= cnt_q;
      if (pop) begin
        last_q <= item_i.last;
      end
      if (fin2) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLimbs; i++) begin
        acc_q[i] <= '0;
      end
    end else if (fin2) begin
      for (int i = 0; i < NumLimbs; i++) begin
        acc_q[i] <= '0;
      end
    end else if (wrap) begin
      acc_q[0] <= AccW'(h0w[LimbW-1:0]);
      acc_q[1] <= acc_q[1] + AccW'(h0w[38:LimbW]);
    end else if (prod_v_q) begin
      acc_q[prod_k_q] <= AccW'(full[LimbW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < NumLimbs; i++) begin
        hs_q[i] <= SumW'(acc_q[i]) + SumW'(tl[i]);
      end
      coef_q[0] <= CoefW'(rl[0]);
      for (int i = 1; i < NumLimbs; i++) begin
        coef_q[i] <= times5(rl[NumLimbs-i]);
      end
      for (int j = 0; j < NumLimbs - 1; j++) begin
        rsh_q[j] <= rl[j+1];
      end
      carry_q <= '0;
    end else begin
      if (mul) begin
        for (int i = 0; i < NumLimbs; i++) begin
          prod_q[i] <= ProdW'(hs_q[i]) * ProdW'(coef_q[i]);
        end
        coef_q[0] <= CoefW'(rsh_q[0]);
        for (int i = 1; i < NumLimbs; i++) begin
          coef_q[i] <= coef_q[i-1];
        end
        for (int j = 0; j < NumLimbs - 2; j++) begin
          rsh_q[j] <= rsh_q[j+1];
        end
        rsh_q[NumLimbs-2] <= '0;
      end
      if (prod_v_q) begin
        carry_q <= CarryW'(full[DigW-1:LimbW]);
      end
    end
    if (fin1) begin
      for (int i = 0; i < NumLimbs; i++) begin
        fin_q[i] <= AccW'(x[i]);
      end
    end
    if (fin2) begin
      tag_q <= tag_d;
    end
  end

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign tag_o       = tag_q;
  assign st_o.idle   = (state_q == ST_IDLE);
  assign st_o.fin    = fin2;

endmodule

>>> rtl/poly1305_mac.sv
// ----------------------------------------------------------------------------
// Poly1305 MAC top level
// A block that absorbs data passes through MUL, SUM and WRAP; a last item
// then also passes through FIN1 and FIN2, and an empty last item goes from
// IDLE to FIN1 and FIN2. Blocks with no bytes that are not last are dropped
// at the input. The five-row multiply sequence sets the rate. A final item
// is queued and popped before these states, then its tag is registered.
// Reset clears the key registers, the accumulator, the queue and out_valid_o.
// ----------------------------------------------------------------------------
module poly1305_mac (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  input  logic [4:0]  block_bytes_i,
  input  logic        last_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [63:0] tag_low_o,
  output logic [63:0] tag_high_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);
  import p1305_pkg::*;

  logic [63:0]    key_r_low_q, key_r_high_q, key_s_low_q, key_s_high_q;
  logic           push, pop;
  p1305_item_t    front_item, head_item;
  p1305_fifo_st_t fifo_st;
  p1305_core_st_t core_st;
  logic [127:0]   tag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_r_low_q  <= '0;
      key_r_high_q <= '0;
      key_s_low_q  <= '0;
      key_s_high_q <= '0;
    end else if (cfg_we_i) begin
      case (p1305_reg_e'(cfg_idx_i))
        REG_KEY_R_LOW:  key_r_low_q  <= cfg_wdata_i;
        REG_KEY_R_HIGH: key_r_high_q <= cfg_wdata_i;
        REG_KEY_S_LOW:  key_s_low_q  <= cfg_wdata_i;
        REG_KEY_S_HIGH: key_s_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  p1305_front u_front (
    .block_low_i   (block_low_i),
    .block_high_i  (block_high_i),
    .block_bytes_i (block_bytes_i),
    .last_i        (last_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .fifo_st_i     (fifo_st),
    .push_o        (push),
    .item_o        (front_item)
  );

  p1305_fifo #(
    .Depth (2)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (head_item),
    .st_o   (fifo_st)
  );

  p1305_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_st_i   (fifo_st),
    .item_i      (head_item),
    .pop_o       (pop),
    .key_r_i     ({key_r_high_q, key_r_low_q}),
    .key_s_i     ({key_s_high_q, key_s_low_q}),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tag_o       (tag),
    .st_o        (core_st)
  );

  assign tag_low_o  = tag[63:0];
  assign tag_high_o = tag[127:64];

`ifndef SYNTH
  a_fifo_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_st.full && fifo_st.empty))
    else $error("Queue reports full and empty together.");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !fifo_st.empty)
    else $error("Pushed item is missing from the queue.");

  a_tag_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(core_st.fin))
    else $error("Tag shown without a finishing step.");

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_st.fin |=> core_st.idle)
    else $error("Core did not return to idle after finishing.");
`endif

endmodule
